@@ rtl/core/tcw_pkg.sv @@
// Text console writer package: screen geometry, command and character codes,
// datapath operation codes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_STOP  = 4;    // power of two
	localparam int CELLS     = COLUMNS * ROWS;

	localparam int COL_W     = $clog2(COLUMNS);
	localparam int ROW_W     = $clog2(ROWS);
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int TAB_W     = $clog2(TAB_STOP + 1);
	localparam int TAB_MOD_W = $clog2(TAB_STOP);

	// Command codes
	localparam logic [2:0] CMD_PUT    = 3'd0;
	localparam logic [2:0] CMD_WRITE  = 3'd1;
	localparam logic [2:0] CMD_SET    = 3'd2;
	localparam logic [2:0] CMD_MOVE   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;
	localparam logic [2:0] CMD_SCROLL = 3'd5;
	localparam logic [2:0] CMD_READ   = 3'd6;

	// Control characters
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_RETURN  = 8'h0D;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_BACK    = 8'h08;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam logic [7:0]  COLOR_RESET = 8'h07;
	localparam logic [15:0] CELL_RESET  = 16'h0720;

	// Datapath operations, one per cycle
	typedef logic [4:0] op_t;
	localparam op_t OP_NONE    = 5'd0;
	localparam op_t OP_LOAD    = 5'd1;   // latch input item
	localparam op_t OP_INIT_WR = 5'd2;   // clearing pass after reset
	localparam op_t OP_FILL_WR = 5'd3;   // blank cell at sweep address
	localparam op_t OP_COPY_RD = 5'd4;   // scroll copy: read source
	localparam op_t OP_PUT     = 5'd5;   // write char at cursor, advance
	localparam op_t OP_BACK    = 5'd6;   // backspace
	localparam op_t OP_CR      = 5'd7;
	localparam op_t OP_NL      = 5'd8;
	localparam op_t OP_WRCELL  = 5'd9;
	localparam op_t OP_SETCUR  = 5'd10;
	localparam op_t OP_MOVE    = 5'd11;
	localparam op_t OP_CLEAR   = 5'd12;  // home cursor, sweep from 0
	localparam op_t OP_SCROLL  = 5'd13;  // start copy by scroll_count rows
	localparam op_t OP_FILL0   = 5'd14;  // sweep whole screen
	localparam op_t OP_READ    = 5'd15;
	localparam op_t OP_TAB     = 5'd16;  // load tab space count
	localparam op_t OP_ONE     = 5'd17;  // load single put
	localparam op_t OP_EMIT    = 5'd18;  // load output register

	typedef struct packed {
		op_t op;
	} tcw_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       is_nl;
		logic       is_cr;
		logic       is_tab;
		logic       is_bs;
		logic       col_zero;
		logic       row_last;
		logic       wrap_bottom;  // put would wrap off the last row
		logic       cnt_zero;
		logic       cnt_big;
		logic       put_last;
		logic       put_more;
		logic       copy_last;
		logic       fill_last;
		logic       out_free;
		logic       wr_en;
	} tcw_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/tcw_datapath.sv @@
// Text console writer datapath: screen store, cursor, colour register,
// sweep counter for clear/scroll, and the output register.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  tcw_pkg::tcw_cmd_t cmd,
	output tcw_pkg::tcw_stat_t stat,
	input  logic [2:0]        command,
	input  logic [7:0]        char_code,
	input  logic [7:0]        cell_attr,
	input  logic [7:0]        pos_x,
	input  logic [7:0]        pos_y,
	input  logic [15:0]       delta_x,
	input  logic [15:0]       delta_y,
	input  logic [7:0]        scroll_count,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              status,
	output logic [6:0]        cursor_col,
	output logic [4:0]        cursor_row,
	output logic [7:0]        read_char,
	output logic [7:0]        read_attr
);
	import tcw_pkg::*;

	// Latched item
	logic [2:0]  cmd_q;
	logic [7:0]  char_q, attr_q, px_q, py_q, cnt_q;
	logic [15:0] dx_q, dy_q;

	// Control state
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [7:0]        color_q;
	logic [ADDR_W-1:0] addr_q, off_q;
	logic [TAB_W-1:0]  put_cnt_q;
	logic              err_q, rd_hit_q, out_valid_q;

	// Copy pipeline
	logic              cp_v_s1;
	logic [ADDR_W-1:0] dst_s1;

	// Store
	logic [15:0]       mem [CELLS];
	logic [15:0]       rd_data_q;

	// Output register
	logic              status_q;
	logic [COL_W-1:0]  ocol_q;
	logic [ROW_W-1:0]  orow_q;
	logic [7:0]        ochar_q, oattr_q;

	logic              pos_ok, col_last, row_last;
	logic [ADDR_W-1:0] cur_addr, pos_addr, src_addr;
	logic [15:0]       blank;
	logic [7:0]        put_char;
	logic signed [16:0] nx, ny;
	logic [COL_W-1:0]  nx_cl;
	logic [ROW_W-1:0]  ny_cl;
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [15:0]       wr_data;

	// Addresses and flags
	assign pos_ok   = (px_q < 8'(COLUMNS)) && (py_q < 8'(ROWS));
	assign col_last = col_q == COL_W'(COLUMNS - 1);
	assign row_last = row_q == ROW_W'(ROWS - 1);
	assign cur_addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign pos_addr = ADDR_W'(py_q[ROW_W-1:0]) * ADDR_W'(COLUMNS)
		+ ADDR_W'(px_q[COL_W-1:0]);
	assign src_addr = addr_q + off_q;
	assign blank    = {color_q, CH_SPACE};
	assign put_char = (char_q == CH_TAB) ? CH_SPACE : char_q;

	// Move cursor with clamping
	assign nx = $signed({10'd0, col_q}) + $signed({dx_q[15], dx_q});
	assign ny = $signed({12'd0, row_q}) + $signed({dy_q[15], dy_q});
	always_comb begin
		if (nx[16])
			nx_cl = '0;
		else if (nx > $signed(17'(COLUMNS - 1)))
			nx_cl = COL_W'(COLUMNS - 1);
		else
			nx_cl = nx[COL_W-1:0];
		if (ny[16])
			ny_cl = '0;
		else if (ny > $signed(17'(ROWS - 1)))
			ny_cl = ROW_W'(ROWS - 1);
		else
			ny_cl = ny[ROW_W-1:0];
	end

	// Write port: copy pipeline has the port while it runs
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = blank;
		if (cp_v_s1) begin
			wr_en   = 1'b1;
			wr_addr = dst_s1;
			wr_data = rd_data_q;
		end else begin
			case (cmd.op)
				OP_INIT_WR: begin
					wr_en   = 1'b1;
					wr_data = CELL_RESET;
				end
				OP_FILL_WR: wr_en = 1'b1;
				OP_PUT: begin
					wr_en   = 1'b1;
					wr_addr = cur_addr;
					wr_data = {color_q, put_char};
				end
				OP_BACK: begin
					wr_en   = 1'b1;
					wr_addr = cur_addr - ADDR_W'(1);
				end
				OP_WRCELL: begin
					wr_en   = pos_ok;
					wr_addr = pos_addr;
					wr_data = {attr_q, char_q};
				end
				default: wr_en = 1'b0;
			endcase
		end
	end

	// Read port
	assign rd_en   = (cmd.op == OP_COPY_RD) || ((cmd.op == OP_READ) && pos_ok);
	assign rd_addr = (cmd.op == OP_COPY_RD) ? src_addr : pos_addr;

	// Screen store
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			color_q     <= COLOR_RESET;
			addr_q      <= '0;
			off_q       <= '0;
			put_cnt_q   <= '0;
			err_q       <= 1'b0;
			rd_hit_q    <= 1'b0;
			cp_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				color_q <= cfg_data;
			cp_v_s1 <= cmd.op == OP_COPY_RD;
			if (cmd.op == OP_EMIT)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (cmd.op)
				OP_LOAD: begin
					put_cnt_q <= '0;
					err_q     <= 1'b0;
					rd_hit_q  <= 1'b0;
				end
				OP_INIT_WR, OP_FILL_WR, OP_COPY_RD: addr_q <= addr_q + ADDR_W'(1);
				OP_PUT: begin
					put_cnt_q <= put_cnt_q - TAB_W'(1);
					if (col_last) begin
						col_q <= '0;
						if (row_last) begin
							addr_q <= '0;
							off_q  <= ADDR_W'(COLUMNS);
						end else begin
							row_q <= row_q + ROW_W'(1);
						end
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				OP_BACK: col_q <= col_q - COL_W'(1);
				OP_CR:   col_q <= '0;
				OP_NL: begin
					col_q <= '0;
					if (row_last) begin
						addr_q <= '0;
						off_q  <= ADDR_W'(COLUMNS);
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				OP_WRCELL: err_q <= !pos_ok;
				OP_SETCUR: begin
					err_q <= !pos_ok;
					if (pos_ok) begin
						col_q <= px_q[COL_W-1:0];
						row_q <= py_q[ROW_W-1:0];
					end
				end
				OP_MOVE: begin
					col_q <= nx_cl;
					row_q <= ny_cl;
				end
				OP_CLEAR: begin
					col_q  <= '0;
					row_q  <= '0;
					addr_q <= '0;
				end
				OP_SCROLL: begin
					addr_q <= '0;
					off_q  <= ADDR_W'(cnt_q[ROW_W-1:0]) * ADDR_W'(COLUMNS);
				end
				OP_FILL0: addr_q <= '0;
				OP_READ: begin
					err_q    <= !pos_ok;
					rd_hit_q <= pos_ok;
				end
				OP_TAB: put_cnt_q <= TAB_W'(TAB_STOP) - TAB_W'(col_q[TAB_MOD_W-1:0]);
				OP_ONE: put_cnt_q <= TAB_W'(1);
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			cmd_q  <= command;
			char_q <= char_code;
			attr_q <= cell_attr;
			px_q   <= pos_x;
			py_q   <= pos_y;
			dx_q   <= delta_x;
			dy_q   <= delta_y;
			cnt_q  <= scroll_count;
		end
		dst_s1 <= addr_q;
		if (cmd.op == OP_EMIT) begin
			status_q <= err_q;
			ocol_q   <= col_q;
			orow_q   <= row_q;
			ochar_q  <= rd_hit_q ? rd_data_q[7:0] : 8'd0;
			oattr_q  <= rd_hit_q ? rd_data_q[15:8] : 8'd0;
		end
	end

	// Status to controller
	always_comb begin
		stat.cmd         = cmd_q;
		stat.is_nl       = char_q == CH_NEWLINE;
		stat.is_cr       = char_q == CH_RETURN;
		stat.is_tab      = char_q == CH_TAB;
		stat.is_bs       = char_q == CH_BACK;
		stat.col_zero    = col_q == '0;
		stat.row_last    = row_last;
		stat.wrap_bottom = col_last && row_last;
		stat.cnt_zero    = cnt_q == 8'd0;
		stat.cnt_big     = cnt_q >= 8'(ROWS);
		stat.put_last    = put_cnt_q == TAB_W'(1);
		stat.put_more    = put_cnt_q != '0;
		stat.copy_last   = src_addr == ADDR_W'(CELLS - 1);
		stat.fill_last   = addr_q == ADDR_W'(CELLS - 1);
		stat.out_free    = !out_valid_q || !out_stall;
		stat.wr_en       = wr_en;
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign cursor_col = ocol_q;
	assign cursor_row = orow_q;
	assign read_char  = ochar_q;
	assign read_attr  = oattr_q;

endmodule

`default_nettype wire

@@ rtl/core/tcw_ctrl.sv @@
// Text console writer controller: sequences clearing pass, command decode,
// character puts, scroll copy and blank sweeps.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tcw_pkg::tcw_stat_t stat,
	output tcw_pkg::tcw_cmd_t  cmd
);
	import tcw_pkg::*;

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_PUT   = 4'd3;
	localparam logic [3:0] S_COPY  = 4'd4;
	localparam logic [3:0] S_DRAIN = 4'd5;
	localparam logic [3:0] S_FILL  = 4'd6;
	localparam logic [3:0] S_DONE  = 4'd7;

	logic [3:0] state_q, state_d;

	// Next state and operation
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_INIT: begin
				cmd.op = OP_INIT_WR;
				if (stat.fill_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_DONE;
				case (stat.cmd)
					CMD_PUT: begin
						if (stat.is_nl) begin
							cmd.op = OP_NL;
							if (stat.row_last)
								state_d = S_COPY;
						end else if (stat.is_cr) begin
							cmd.op = OP_CR;
						end else if (stat.is_tab) begin
							cmd.op  = OP_TAB;
							state_d = S_PUT;
						end else if (stat.is_bs) begin
							cmd.op = stat.col_zero ? OP_NONE : OP_BACK;
						end else begin
							cmd.op  = OP_ONE;
							state_d = S_PUT;
						end
					end
					CMD_WRITE: cmd.op = OP_WRCELL;
					CMD_SET:   cmd.op = OP_SETCUR;
					CMD_MOVE:  cmd.op = OP_MOVE;
					CMD_CLEAR: begin
						cmd.op  = OP_CLEAR;
						state_d = S_FILL;
					end
					CMD_SCROLL: begin
						if (stat.cnt_big) begin
							cmd.op  = OP_FILL0;
							state_d = S_FILL;
						end else if (!stat.cnt_zero) begin
							cmd.op  = OP_SCROLL;
							state_d = S_COPY;
						end
					end
					CMD_READ: cmd.op = OP_READ;
					default:  cmd.op = OP_NONE;
				endcase
			end
			// One cell per cycle; wrapping off the bottom scrolls one row
			S_PUT: begin
				cmd.op = OP_PUT;
				if (stat.wrap_bottom)
					state_d = S_COPY;
				else if (stat.put_last)
					state_d = S_DONE;
			end
			S_COPY: begin
				cmd.op = OP_COPY_RD;
				if (stat.copy_last)
					state_d = S_DRAIN;
			end
			// Last copied cell is written this cycle
			S_DRAIN: state_d = S_FILL;
			S_FILL: begin
				cmd.op = OP_FILL_WR;
				if (stat.fill_last)
					state_d = stat.put_more ? S_PUT : S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_INIT;
		else
			state_q <= state_d;
	end

	assign in_stall = state_q != S_IDLE;

endmodule

`default_nettype wire

@@ rtl/core/text_console_writer.sv @@
// Text console writer top level: controller plus datapath, configuration
// register write port and assertions.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath.
`timescale 1ns / 1ps
`default_nettype none

// An 80 x 25 character-cell screen with a cursor, driven one command at a
// time. After reset the block runs a clearing pass, filling every cell with
// a grey-on-black space, and holds in_stall high until it is done. All
// screen traffic goes through one write port and one read port of the cell
// store, one cell a cycle. A scroll by n rows below the screen height
// copies the surviving rows, then blanks the n new rows, and a newline or
// wrap on the bottom row costs the same one-row scroll. text_color is
// written through the cfg channel (always ready) and must only change
// while the block is idle. Results sit in an output register, so a new
// command can be taken while the previous result is still stalled.
module text_console_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  char_code,
	input  logic [7:0]  cell_attr,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [15:0] delta_x,
	input  logic [15:0] delta_y,
	input  logic [7:0]  scroll_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [7:0]  read_char,
	output logic [7:0]  read_attr,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import tcw_pkg::*;

	tcw_cmd_t  cmd;
	tcw_stat_t stat;

	assign cfg_ready = 1'b1;

	// Sequencer
	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Store, cursor and output register
	tcw_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.command      (command),
		.char_code    (char_code),
		.cell_attr    (cell_attr),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.scroll_count (scroll_count),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.read_char    (read_char),
		.read_attr    (read_attr)
	);

	// Reported cursor always lies on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor_col < 7'(COLUMNS)) && (cursor_row < 5'(ROWS)))
		else $error("cursor outside screen");

	// A rejected position never returns cell contents
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (read_char == 8'd0) && (read_attr == 8'd0))
		else $error("read data on invalid status");

	// One command at a time: a transfer closes the input
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open after transfer");

	// The store is quiet while waiting for a command
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !stat.wr_en)
		else $error("store written while idle");

endmodule

`default_nettype wire

@@ tb/text_console_writer_test.sv @@
// Self-checking testbench for text_console_writer: a scoreboard class tracks the
// screen cells, cursor and colour to predict every result; plain tasks drive it.
// Depends on tcw_pkg and text_console_writer.
`timescale 1ns / 1ps

module text_console_writer_test;
	import tcw_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int PHASE_ITEMS  = 374;
	localparam int QUIET_FIRST  = 700;      // no idling on either side in this stretch
	localparam int QUIET_LAST   = 1000;
	localparam int HOLD_AT      = 300;      // results taken before the long hold-off
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 50;
	localparam longint CYCLE_LIMIT = 12_000_000;

	typedef struct packed {
		bit [2:0]  command;
		bit [7:0]  char_code;
		bit [7:0]  cell_attr;
		bit [7:0]  pos_x;
		bit [7:0]  pos_y;
		bit [15:0] delta_x;
		bit [15:0] delta_y;
		bit [7:0]  scroll_count;
	} console_cmd_t;

	typedef struct packed {
		logic       status;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic [7:0] read_char;
		logic [7:0] read_attr;
	} console_result_t;

	// Screen, cursor and colour mirror; one expected result per command
	class console_scoreboard;
		bit [15:0] screen [CELLS];
		int cur_x;
		int cur_y;
		bit [7:0] color;
		console_result_t expected_q[$];
		int mismatches;

		function new();
			foreach (screen[i])
				screen[i] = CELL_RESET;
			cur_x = 0;
			cur_y = 0;
			color = COLOR_RESET;
			mismatches = 0;
		endfunction

		function void set_color(bit [7:0] c);
			color = c;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Move rows up by n; n of ROWS or more blanks the lot
		function void scroll_up(int n);
			int first_blank;
			if (n == 0)
				return;
			if (n >= ROWS) begin
				first_blank = 0;
			end else begin
				for (int i = 0; i < (ROWS - n) * COLUMNS; i++)
					screen[i] = screen[i + n * COLUMNS];
				first_blank = (ROWS - n) * COLUMNS;
			end
			for (int i = first_blank; i < CELLS; i++)
				screen[i] = {color, CH_SPACE};
		endfunction

		function void line_feed();
			cur_x = 0;
			if (cur_y + 1 >= ROWS) begin
				cur_y = ROWS - 1;
				scroll_up(1);
			end else begin
				cur_y++;
			end
		endfunction

		function void put_cell(bit [7:0] c);
			screen[cur_y * COLUMNS + cur_x] = {color, c};
			cur_x++;
			if (cur_x >= COLUMNS)
				line_feed();
		endfunction

		function void put_char(bit [7:0] c);
			int spaces;
			case (c)
				CH_NEWLINE: line_feed();
				CH_RETURN:  cur_x = 0;
				CH_TAB: begin
					spaces = TAB_STOP - (cur_x % TAB_STOP);
					repeat (spaces)
						put_cell(CH_SPACE);
				end
				CH_BACK: begin
					if (cur_x > 0) begin
						cur_x--;
						screen[cur_y * COLUMNS + cur_x] = {color, CH_SPACE};
					end
				end
				default: put_cell(c);
			endcase
		endfunction

		function void note_input(console_cmd_t it);
			console_result_t r;
			bit in_range;
			int dx, dy, nx, ny, idx;
			r = '0;
			in_range = (it.pos_x < COLUMNS) && (it.pos_y < ROWS);
			idx = it.pos_y * COLUMNS + it.pos_x;
			case (it.command)
				CMD_PUT: put_char(it.char_code);
				CMD_WRITE: begin
					if (in_range)
						screen[idx] = {it.cell_attr, it.char_code};
					else
						r.status = 1'b1;
				end
				CMD_SET: begin
					if (in_range) begin
						cur_x = it.pos_x;
						cur_y = it.pos_y;
					end else begin
						r.status = 1'b1;
					end
				end
				CMD_MOVE: begin
					dx = $signed(it.delta_x);
					dy = $signed(it.delta_y);
					nx = cur_x + dx;
					ny = cur_y + dy;
					cur_x = (nx < 0) ? 0 : (nx >= COLUMNS) ? COLUMNS - 1 : nx;
					cur_y = (ny < 0) ? 0 : (ny >= ROWS) ? ROWS - 1 : ny;
				end
				CMD_CLEAR: begin
					scroll_up(ROWS);
					cur_x = 0;
					cur_y = 0;
				end
				CMD_SCROLL: scroll_up(it.scroll_count);
				CMD_READ: begin
					if (in_range)
						{r.read_attr, r.read_char} = screen[idx];
					else
						r.status = 1'b1;
				end
				default: ;
			endcase
			r.cursor_col = cur_x[6:0];
			r.cursor_row = cur_y[4:0];
			expected_q.push_back(r);
		endfunction

		function void check_result(console_result_t got);
			console_result_t want;
			bit bad;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: %p", $time, got);
				return;
			end
			want = expected_q.pop_front();
			bad = (got.status !== want.status) || (got.cursor_col !== want.cursor_col) ||
				(got.cursor_row !== want.cursor_row) || (got.read_char !== want.read_char) ||
				(got.read_attr !== want.read_attr);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: expected %p, got %p", $time, want, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  command;
	logic [7:0]  char_code;
	logic [7:0]  cell_attr;
	logic [7:0]  pos_x;
	logic [7:0]  pos_y;
	logic [15:0] delta_x;
	logic [15:0] delta_y;
	logic [7:0]  scroll_count;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic [7:0]  read_char;
	logic [7:0]  read_attr;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	console_scoreboard board;
	int     items_sent;
	int     results_taken;
	int     hold_left;
	bit     hold_done;
	longint cycles;

	text_console_writer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.char_code    (char_code),
		.cell_attr    (cell_attr),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.scroll_count (scroll_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.read_char    (read_char),
		.read_attr    (read_attr),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Result side: random stalls, one long hold-off, a quiet stretch
	initial begin
		out_stall = 1'b0;
		results_taken = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				board.check_result({status, cursor_col, cursor_row, read_char, read_attr});
				results_taken++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (results_taken == HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (results_taken >= QUIET_FIRST && results_taken < QUIET_LAST) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 30);
			end
		end
	end

	// Offer one command and hold it until the transfer
	task automatic send_item(console_cmd_t it);
		int gap;
		if ((items_sent < QUIET_FIRST || items_sent >= QUIET_LAST) &&
				$urandom_range(99) < 30) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= it.command;
		char_code    <= it.char_code;
		cell_attr    <= it.cell_attr;
		pos_x        <= it.pos_x;
		pos_y        <= it.pos_y;
		delta_x      <= it.delta_x;
		delta_y      <= it.delta_y;
		scroll_count <= it.scroll_count;
		do
			@(posedge clk);
		while (in_stall);
		board.note_input(it);
		items_sent++;
	endtask

	task automatic send_fields(bit [2:0] cmd, bit [7:0] ch, bit [7:0] attr, bit [7:0] px,
			bit [7:0] py, bit [15:0] dx, bit [15:0] dy, bit [7:0] cnt);
		send_item('{cmd, ch, attr, px, py, dx, dy, cnt});
	endtask

	// Drop valid and wait for every outstanding result
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_text_color(bit [7:0] c);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.set_color(c);
		cfg_valid <= 1'b0;
	endtask

	function automatic console_cmd_t random_command();
		console_cmd_t it;
		int pick;
		int sel;
		it.command      = CMD_UNUSED;
		it.char_code    = 8'($urandom);
		it.cell_attr    = 8'($urandom);
		it.pos_x        = 8'($urandom);
		it.pos_y        = 8'($urandom);
		it.delta_x      = 16'($urandom);
		it.delta_y      = 16'($urandom);
		it.scroll_count = 8'($urandom);
		// mostly on-screen positions, the rest anywhere in the byte range
		if ($urandom_range(99) < 85) begin
			it.pos_x = 8'($urandom_range(COLUMNS - 1));
			it.pos_y = 8'($urandom_range(ROWS - 1));
		end
		pick = $urandom_range(99);
		sel = $urandom_range(99);
		if (pick < 40) begin
			it.command = CMD_PUT;
			if (sel < 5)
				it.char_code = CH_NEWLINE;
			else if (sel < 10)
				it.char_code = CH_RETURN;
			else if (sel < 20)
				it.char_code = CH_TAB;
			else if (sel < 30)
				it.char_code = CH_BACK;
		end else if (pick < 52) begin
			it.command = CMD_WRITE;
		end else if (pick < 62) begin
			it.command = CMD_SET;
		end else if (pick < 72) begin
			it.command = CMD_MOVE;
			if (sel < 50) begin
				it.delta_x = 16'($urandom_range(6)) - 16'd3;
				it.delta_y = 16'($urandom_range(6)) - 16'd3;
			end else if (sel >= 75) begin
				it.delta_x = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
				it.delta_y = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
			end
		end else if (pick < 93) begin
			it.command = CMD_READ;
		end else if (pick < 95) begin
			it.command = CMD_CLEAR;
		end else if (pick < 98) begin
			it.command = CMD_SCROLL;
			if (sel < 10)
				it.scroll_count = 8'd0;
			else if (sel < 75)
				it.scroll_count = 8'($urandom_range(1, 3));
			else if (sel < 90)
				it.scroll_count = 8'($urandom_range(ROWS - 1, ROWS));
		end
		return it;
	endfunction

	initial begin
		bit [7:0] colors [5];
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = '0;
		char_code    = '0;
		cell_attr    = '0;
		pos_x        = '0;
		pos_y        = '0;
		delta_x      = '0;
		delta_y      = '0;
		scroll_count = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		items_sent   = 0;
		board = new();
		colors = '{8'h00, 8'hFF, 8'h1E, 8'($urandom), 8'($urandom)};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// block fills the screen after reset before taking commands
		do
			@(posedge clk);
		while (in_stall);

		// Directed: reset contents, control characters, edges, bad positions
		send_fields(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_PUT, 8'h41, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_PUT, 8'hFF, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_PUT, 8'h00, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_PUT, CH_TAB, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_PUT, CH_BACK, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_PUT, CH_RETURN, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_PUT, CH_BACK, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_PUT, CH_NEWLINE, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_WRITE, 8'h5A, 8'hFF, 8'(COLUMNS - 1), 8'(ROWS - 1), 0, 0, 0);
		send_fields(CMD_WRITE, 8'h33, 8'h44, 8'(COLUMNS), 0, 0, 0, 0);
		send_fields(CMD_WRITE, 8'h33, 8'h44, 8'hFF, 8'hFF, 0, 0, 0);
		send_fields(CMD_SET, 0, 0, 8'(COLUMNS - 1), 8'(ROWS - 1), 0, 0, 0);
		// wrap off the bottom row scrolls
		send_fields(CMD_PUT, 8'h42, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_READ, 0, 0, 8'(COLUMNS - 1), 8'(ROWS - 2), 0, 0, 0);
		send_fields(CMD_SET, 0, 0, 8'(COLUMNS), 0, 0, 0, 0);
		send_fields(CMD_SET, 0, 0, 0, 8'(ROWS), 0, 0, 0);
		send_fields(CMD_MOVE, 0, 0, 0, 0, 16'h8000, 16'h8000, 0);
		send_fields(CMD_MOVE, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF, 0);
		send_fields(CMD_MOVE, 0, 0, 0, 0, 16'hFFFD, 16'h0002, 0);
		send_fields(CMD_PUT, CH_NEWLINE, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_READ, 0, 0, 0, 8'(ROWS), 0, 0, 0);
		send_fields(CMD_SCROLL, 0, 0, 0, 0, 0, 0, 8'd0);
		send_fields(CMD_SCROLL, 0, 0, 0, 0, 0, 0, 8'd3);
		send_fields(CMD_SCROLL, 0, 0, 0, 0, 0, 0, 8'(ROWS));
		send_fields(CMD_SCROLL, 0, 0, 0, 0, 0, 0, 8'hFF);
		send_fields(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		send_fields(CMD_UNUSED, 8'hA5, 8'h5A, 8'h12, 8'h08, 16'h1234, 16'h4321, 8'h02);
		// tab ending at the line end on the bottom row, so it wraps and scrolls
		send_fields(CMD_SET, 0, 0, 8'(COLUMNS - 2), 8'(ROWS - 1), 0, 0, 0);
		send_fields(CMD_PUT, CH_TAB, 0, 0, 0, 0, 0, 0);

		// Random phases, each under its own text colour
		foreach (colors[p]) begin
			wait_drained();
			write_text_color(colors[p]);
			repeat (PHASE_ITEMS)
				send_item(random_command());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/tcw_pkg.sv
rtl/core/tcw_datapath.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer.sv
tb/text_console_writer_test.sv
